// File: hw/rtl/cia_pkg.sv
// Shared types and constants for the checked integer ALU.
// Used by cia_ctrl, cia_dp and checked_integer_alu_top; no dependencies.
`default_nettype none
package cia_pkg;
	localparam int OPC_W   = 3;
	localparam int FIELD_W = 64;
	localparam int STAT_W  = 2;

	localparam logic [OPC_W-1:0] OP_ADD = 3'd0;
	localparam logic [OPC_W-1:0] OP_SUB = 3'd1;
	localparam logic [OPC_W-1:0] OP_MUL = 3'd2;
	localparam logic [OPC_W-1:0] OP_POW = 3'd3;
	localparam logic [OPC_W-1:0] OP_DIV = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [STAT_W-1:0] ST_DIVZERO  = 2'd2;
	localparam logic [STAT_W-1:0] ST_NEGEXP   = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture a new transaction
		logic check;     // simple ops, special cases, loop setup
		logic fin_acc;   // power loop finished: result is the accumulator
		logic mul_init;
		logic mul_step;
		logic mul_check; // overflow test and accumulator update
		logic div_init;
		logic div_step;
		logic div_fin;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_mul;
		logic need_div;
		logic pow_zero;  // no multiplies left
		logic bits_done; // last shift/add or shift/subtract step
		logic mul_ovf;
	} sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/cia_ctrl.sv
// Controller state machine of the checked integer ALU.
// Depends on cia_pkg for the command and status structs.
`default_nettype none
module cia_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           out_ready,
	input  wire cia_pkg::sts_t  sts,
	output cia_pkg::cmd_t       cmd,
	output logic                in_ready,
	output logic                out_valid
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_CHECK = 8'b00000010,
		S_MINIT = 8'b00000100,
		S_MUL   = 8'b00001000,
		S_MCHK  = 8'b00010000,
		S_DIV   = 8'b00100000,
		S_DFIN  = 8'b01000000,
		S_DONE  = 8'b10000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.need_mul) state_d = S_MINIT;
				else if (sts.need_div) begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end else state_d = S_DONE;
			end
			S_MINIT: begin
				if (sts.pow_zero) begin
					cmd.fin_acc = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.mul_init = 1'b1;
					state_d      = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.bits_done) state_d = S_MCHK;
			end
			S_MCHK: begin
				cmd.mul_check = 1'b1;
				state_d       = sts.mul_ovf ? S_DONE : S_MINIT;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.bits_done) state_d = S_DFIN;
			end
			S_DFIN: begin
				cmd.div_fin = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
endmodule
`default_nettype wire

// File: hw/rtl/cia_dp.sv
// Datapath of the checked integer ALU: operand registers, shift/add
// multiplier, restoring divider and result register. Depends on cia_pkg.
`default_nettype none
module cia_dp #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                           clk,
	input  wire cia_pkg::cmd_t                  cmd,
	input  wire logic [cia_pkg::OPC_W-1:0]      opcode,
	input  wire logic [cia_pkg::FIELD_W-1:0]    operand_a,
	input  wire logic [cia_pkg::FIELD_W-1:0]    operand_b,
	output cia_pkg::sts_t                       sts,
	output logic signed [cia_pkg::FIELD_W-1:0]  value,
	output logic [cia_pkg::STAT_W-1:0]          status
);
	localparam int W  = DATA_WIDTH;
	localparam int CW = $clog2(W + 1);

	logic [cia_pkg::OPC_W-1:0] op_q;
	logic signed [W-1:0] a_q, b_q, acc_q, mulb_q, value_q;
	logic [cia_pkg::STAT_W-1:0] status_q;
	logic [W-1:0]   mcand_q, dvs_q, rem_q, quo_q;
	logic [2*W-1:0] prod_q;
	logic           neg_q;
	logic [CW-1:0]  cnt_q;
	logic [6:0]     pow_cnt_q;

	logic signed [W-1:0] min_w;
	logic [W:0]     add_s, sub_s, msum, shifted, diff;
	logic [W-1:0]   bm1, mag_acc, mag_b, mag_a, mag_bb, prod_lo;
	logic           add_ovf, sub_ovf, a_min, ovf_hi, ovf_lo;
	logic [W-1:0]   chk_val;
	logic [cia_pkg::STAT_W-1:0] chk_st;

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		return x[W-1] ? (~x + W'(1)) : x;
	endfunction

	always_comb begin
		min_w   = {1'b1, {(W-1){1'b0}}};
		add_s   = {a_q[W-1], a_q} + {b_q[W-1], b_q};
		sub_s   = {a_q[W-1], a_q} - {b_q[W-1], b_q};
		add_ovf = add_s[W] != add_s[W-1];
		sub_ovf = sub_s[W] != sub_s[W-1];
		a_min   = (a_q == min_w);
		bm1     = b_q - W'(1);
		mag_acc = mag(acc_q);
		mag_b   = mag(mulb_q);
		mag_a   = mag(a_q);
		mag_bb  = mag(b_q);
		msum    = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
		shifted = {rem_q, quo_q[W-1]};
		diff    = shifted - {1'b0, dvs_q};
		prod_lo = prod_q[W-1:0];
		ovf_hi  = |prod_q[2*W-1:W];
		// magnitude limit is MAX, or MAX+1 for a negative product
		ovf_lo  = prod_lo[W-1] && (!neg_q || (|prod_lo[W-2:0]));

		chk_val = '0;
		chk_st  = cia_pkg::ST_OK;
		unique case (op_q)
			cia_pkg::OP_ADD: begin
				if (add_ovf) chk_st = cia_pkg::ST_OVERFLOW;
				else chk_val = add_s[W-1:0];
			end
			cia_pkg::OP_SUB: begin
				if (sub_ovf) chk_st = cia_pkg::ST_OVERFLOW;
				else chk_val = sub_s[W-1:0];
			end
			cia_pkg::OP_MUL: ;
			cia_pkg::OP_POW: begin
				priority if (b_q[W-1]) chk_st = cia_pkg::ST_NEGEXP;
				else if (b_q == '0) chk_val = W'(1);
				else if (a_q == '1) chk_val = b_q[0] ? '1 : W'(1);
				else chk_val = a_q;
			end
			cia_pkg::OP_DIV: begin
				if (b_q == '0) chk_st = cia_pkg::ST_DIVZERO;
				else if (a_min && (b_q == '1)) chk_st = cia_pkg::ST_OVERFLOW;
			end
			default: ;
		endcase
	end

	assign sts.need_mul  = (op_q == cia_pkg::OP_MUL) ||
		((op_q == cia_pkg::OP_POW) && !b_q[W-1] && (b_q != '0) &&
		 (a_q != '0) && (a_q != W'(1)) && (a_q != '1));
	assign sts.need_div  = (op_q == cia_pkg::OP_DIV) && (b_q != '0) &&
		!(a_min && (b_q == '1));
	assign sts.pow_zero  = (pow_cnt_q == '0);
	assign sts.bits_done = (cnt_q == CW'(1));
	assign sts.mul_ovf   = ovf_hi || ovf_lo;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			a_q  <= operand_a[W-1:0];
			b_q  <= operand_b[W-1:0];
		end
		if (cmd.check) begin
			value_q  <= chk_val;
			status_q <= chk_st;
			acc_q    <= a_q;
			if (op_q == cia_pkg::OP_MUL) begin
				mulb_q    <= b_q;
				pow_cnt_q <= 7'd1;
			end else begin
				mulb_q    <= a_q;
				pow_cnt_q <= (bm1 > W'(64)) ? 7'd64 : 7'(bm1);
			end
		end
		if (cmd.fin_acc) begin
			value_q  <= acc_q;
			status_q <= cia_pkg::ST_OK;
		end
		if (cmd.mul_init) begin
			mcand_q <= mag_acc;
			prod_q  <= {{W{1'b0}}, mag_b};
			neg_q   <= acc_q[W-1] ^ mulb_q[W-1];
			cnt_q   <= CW'(W);
		end
		if (cmd.mul_step) begin
			prod_q <= {msum, prod_q[W-1:1]};
			cnt_q  <= cnt_q - CW'(1);
		end
		if (cmd.mul_check) begin
			if (ovf_hi || ovf_lo) begin
				value_q  <= '0;
				status_q <= cia_pkg::ST_OVERFLOW;
			end else begin
				acc_q     <= neg_q ? (~prod_lo + W'(1)) : prod_lo;
				pow_cnt_q <= pow_cnt_q - 7'd1;
			end
		end
		if (cmd.div_init) begin
			quo_q <= mag_a;
			dvs_q <= mag_bb;
			rem_q <= '0;
			neg_q <= a_q[W-1] ^ b_q[W-1];
			cnt_q <= CW'(W);
		end
		if (cmd.div_step) begin
			rem_q <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~diff[W]};
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.div_fin) begin
			value_q  <= neg_q ? (~quo_q + W'(1)) : quo_q;
			status_q <= cia_pkg::ST_OK;
		end
	end

	assign value  = cia_pkg::FIELD_W'(value_q);
	assign status = status_q;
endmodule
`default_nettype wire

// File: hw/rtl/checked_integer_alu_top.sv
// Checked signed integer ALU, top level.
// Instantiates cia_ctrl and cia_dp; depends on cia_pkg.
//
// Usage: one transaction on the s_ group carries opcode and two operands;
// exactly one transaction on the m_ group returns value and status. Operands
// are taken at DATA_WIDTH bits, sign-extended from bit DATA_WIDTH-1, and the
// value is returned sign-extended to 64 bits, 0 whenever status is not ok.
// One transaction is in flight at a time: s_tready is high only when idle.
// Add, subtract and the special cases finish in the check state; multiply
// makes one checked multiply; divide takes one restoring step a cycle; power
// makes one checked multiply per loop pass on the shared shift/add
// multiplier, up to 64 multiplies, ending at the first overflow.
// The result register holds while m_tready is low; the next transaction can be
// accepted the cycle after the result is taken.
// Reset returns the controller to idle with no result pending.
`default_nettype none
module checked_integer_alu_top #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [2:0] opcode, [66:3] operand_a, [130:67] operand_b, [135:131] zero
	input  wire logic [135:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [63:0] value, [65:64] status, [71:66] zero
	output logic [71:0]       m_tdata
);
	cia_pkg::cmd_t cmd;
	cia_pkg::sts_t sts;
	logic signed [cia_pkg::FIELD_W-1:0] value;
	logic [cia_pkg::STAT_W-1:0]         status;

	cia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (s_tready),
		.out_valid (m_tvalid)
	);

	cia_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.opcode    (s_tdata[2:0]),
		.operand_a (s_tdata[66:3]),
		.operand_b (s_tdata[130:67]),
		.sts       (sts),
		.value     (value),
		.status    (status)
	);

	assign m_tdata = {6'd0, status, value};
endmodule
`default_nettype wire

// File: tb/sv/checked_integer_alu_top_test.sv
// Testbench for checked_integer_alu_top: directed and random operations over stream ports.
// Self-contained; depends on cia_pkg and the RTL of checked_integer_alu_top.
`timescale 1ns / 100ps

class alu_scoreboard;
	logic [63:0] exp_value[$];
	logic [1:0]  exp_status[$];
	int          errors;

	function new();
		errors = 0;
	endfunction

	static function bit mul_fits(longint a, longint b, output longint r);
		logic [63:0] ua, ub, lim;
		bit neg;
		r = 0;
		if (a == 0 || b == 0) return 1;
		neg = (a < 0) != (b < 0);
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		lim = 64'h7fff_ffff_ffff_ffff + (neg ? 64'd1 : 64'd0);
		if (ua > lim / ub) return 0;
		r = a * b;
		return 1;
	endfunction

	function void note_operation(logic [2:0] op, longint a, longint b);
		longint maxv, minv, r, acc;
		logic [1:0] st;
		maxv = 64'sh7fff_ffff_ffff_ffff;
		minv = -maxv - 1;
		r = 0;
		st = cia_pkg::ST_OK;
		case (op)
			cia_pkg::OP_ADD: begin
				if ((b > 0 && a > maxv - b) || (b < 0 && a < minv - b)) st = cia_pkg::ST_OVERFLOW;
				else r = a + b;
			end
			cia_pkg::OP_SUB: begin
				if ((b < 0 && a > maxv + b) || (b > 0 && a < minv + b)) st = cia_pkg::ST_OVERFLOW;
				else r = a - b;
			end
			cia_pkg::OP_MUL: begin
				if (!mul_fits(a, b, r)) st = cia_pkg::ST_OVERFLOW;
			end
			cia_pkg::OP_POW: begin
				if (b < 0) st = cia_pkg::ST_NEGEXP;
				else if (b == 0) r = 1;
				else if (a == 0 || a == 1) r = a;
				else if (a == -1) r = b[0] ? -1 : 1;
				else begin
					acc = a;
					for (longint i = 0; i < b - 1 && i < 64; i++)
						if (!mul_fits(acc, a, acc)) begin
							st = cia_pkg::ST_OVERFLOW;
							break;
						end
					r = acc;
				end
			end
			cia_pkg::OP_DIV: begin
				if (b == 0) st = cia_pkg::ST_DIVZERO;
				else if (a == minv && b == -1) st = cia_pkg::ST_OVERFLOW;
				else r = a / b;
			end
			default: r = 0;
		endcase
		if (st != cia_pkg::ST_OK) r = 0;
		exp_value.push_back(r);
		exp_status.push_back(st);
	endfunction

	task report(string what);
		errors++;
		$display("error at %0t: %s", $time, what);
	endtask

	task check_result(logic [71:0] d);
		logic [63:0] v;
		logic [1:0]  s;
		if (exp_value.size() == 0) begin
			report($sformatf("unexpected result %h", d));
			return;
		end
		v = exp_value.pop_front();
		s = exp_status.pop_front();
		if (d[63:0] !== v) report($sformatf("value %h, expected %h", d[63:0], v));
		if (d[65:64] !== s) report($sformatf("status %0d, expected %0d", d[65:64], s));
		if (d[71:66] !== 6'd0) report("padding bits not zero");
	endtask
endclass

module checked_integer_alu_top_test;
	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [71:0]  m_tdata;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	alu_scoreboard sb = new();

	checked_integer_alu_top dut (.*);

	always #5 clk = ~clk;

	// receiver
	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
	end
	always @(negedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// valid stays up after the accept until the next call or drain drops or reloads it
	task send_op(logic [2:0] op, logic [63:0] a, logic [63:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {5'd0, b, a, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_operation(op, a, b);
		@(negedge clk);
	endtask

	function logic [63:0] rand_operand();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(5))
			0: v = $signed(v[7:0]);
			1: v = $signed(v[31:0]);
			2: v = $signed(v[3:0]);
			3: v = {{32{v[63]}}, v[31:0]} >>> $urandom_range(20);
			default: ;
		endcase
		return v;
	endfunction

	task drain();
		s_tvalid <= 0;
		while (sb.exp_value.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	localparam logic [63:0] MAXV = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
	localparam logic [63:0] NEG1 = '1;

	initial begin
		logic [2:0] op;
		logic [63:0] a, b;
		repeat (11) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_op(cia_pkg::OP_ADD, MAXV, 1);
		send_op(cia_pkg::OP_ADD, MINV, NEG1);
		send_op(cia_pkg::OP_ADD, MAXV, MINV);
		send_op(cia_pkg::OP_SUB, 0, MINV);
		send_op(cia_pkg::OP_SUB, NEG1, MINV);
		send_op(cia_pkg::OP_SUB, MINV, 1);
		send_op(cia_pkg::OP_MUL, MINV, NEG1);
		send_op(cia_pkg::OP_MUL, MINV, 1);
		send_op(cia_pkg::OP_MUL, MAXV, MAXV);
		send_op(cia_pkg::OP_MUL, 64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0001);
		send_op(cia_pkg::OP_DIV, 5, 0);
		send_op(cia_pkg::OP_DIV, MINV, NEG1);
		send_op(cia_pkg::OP_DIV, 64'hffff_ffff_ffff_fff9, 2);
		send_op(cia_pkg::OP_DIV, MAXV, MINV);
		send_op(cia_pkg::OP_POW, 7, NEG1);
		send_op(cia_pkg::OP_POW, 0, 0);
		send_op(cia_pkg::OP_POW, 0, MAXV);
		send_op(cia_pkg::OP_POW, 1, MAXV);
		send_op(cia_pkg::OP_POW, NEG1, MAXV);
		send_op(cia_pkg::OP_POW, NEG1, 64'd8);
		send_op(cia_pkg::OP_POW, 64'hffff_ffff_ffff_fffe, 63);
		send_op(cia_pkg::OP_POW, 2, 63);
		send_op(cia_pkg::OP_POW, 3, MAXV);
		send_op(3'd5, MAXV, MAXV);
		send_op(3'd7, MINV, NEG1);
		// sender holds off until everything is back
		drain();
		for (int i = 0; i < 1200; i++) begin
			case (i / 300)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			op = $urandom_range(99) < 4 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
			a = rand_operand();
			b = rand_operand();
			if (op == cia_pkg::OP_POW && $urandom_range(3) != 0) begin
				a = $signed(4'($urandom));
				b = $urandom_range(70);
			end
			send_op(op, a, b);
		end
		drain();
		if (sb.errors == 0)
			$display("checked_integer_alu_top: match");
		else
			$display("checked_integer_alu_top: mismatch");
		$finish;
	end

	initial begin
		#1s;
		$display("checked_integer_alu_top: mismatch");
		$finish;
	end
endmodule

// File: files.f
hw/rtl/cia_pkg.sv
hw/rtl/cia_ctrl.sv
hw/rtl/cia_dp.sv
hw/rtl/checked_integer_alu_top.sv
tb/sv/checked_integer_alu_top_test.sv
